/* hdl/trp_pkg.sv */
// Shared types, constants and ring arithmetic for the torus route generator.
// Used by trp_ctrl, trp_dpath and torus_route_path_generator; no dependencies.
`default_nettype none

package trp_pkg;

  localparam int NODE_W    = 6;
  localparam int GRID_W    = 7;
  localparam int MAX_NODES = 64;
  localparam int ROUTE_CAP = 33;
  localparam int DIV_STEPS = NODE_W;
  localparam int DCNT_W    = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [NODE_W-1:0] LAST_HOP = NODE_W'(ROUTE_CAP - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] hop_index;
    logic              last;
    logic              invalid;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic emit_bad;
    logic div_step;
    logic hop_step;
  } trp_cmd_t;

  typedef struct packed {
    logic bad;
    logic route_done;
  } trp_stat_t;

  // One step along a ring, taking the shorter direction and breaking ties upward.
  function automatic logic [GRID_W-1:0] ring_step(input logic [GRID_W-1:0] from,
                                                  input logic [GRID_W-1:0] to,
                                                  input logic [GRID_W-1:0] size);
    logic [GRID_W-1:0] fwd;
    logic [GRID_W-1:0] bwd;
    logic [GRID_W-1:0] res;
    fwd = (to >= from) ? (to - from) : (to + size - from);
    bwd = (from >= to) ? (from - to) : (from + size - to);
    if (fwd <= bwd) begin
      res = ((from + GRID_W'(1)) == size) ? '0 : (from + GRID_W'(1));
    end else begin
      res = (from == '0) ? (size - GRID_W'(1)) : (from - GRID_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/trp_ctrl.sv */
// Controller state machine for the torus route generator.
// Depends on trp_pkg; drives trp_dpath through command and status structs.
`default_nettype none

module trp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output trp_pkg::trp_cmd_t       cmd,
  input  wire trp_pkg::trp_stat_t stat
);
  import trp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_HOP   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.bad) begin
          cmd.emit_bad = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ST_HOP;
        end
      end
      ST_HOP: begin
        cmd.hop_step = 1'b1;
        if (stat.route_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (dcnt_r != DIV_LAST) |=> (state_r == ST_DIV))
    else $error("division left early");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r <= DIV_LAST))
    else $error("division counter overran");

endmodule

`default_nettype wire

/* hdl/trp_dpath.sv */
// Datapath for the torus route generator: range check, coordinate split by
// shift-subtract division, ring stepping and the result register. Depends on trp_pkg.
`default_nettype none

module trp_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire trp_pkg::in_item_t         in_item,
  input  wire logic [trp_pkg::GRID_W-1:0] grid_rows,
  input  wire logic [trp_pkg::GRID_W-1:0] grid_cols,
  input  wire trp_pkg::trp_cmd_t         cmd,
  output trp_pkg::trp_stat_t             stat,
  output logic                           out_strobe,
  output trp_pkg::out_item_t             out_item
);
  import trp_pkg::*;

  logic [NODE_W-1:0] cr_r, cr_nxt;
  logic [GRID_W-1:0] cc_r, cc_nxt;
  logic [NODE_W-1:0] dr_r, dr_nxt;
  logic [GRID_W-1:0] dc_r, dc_nxt;
  logic [NODE_W-1:0] hop_r, hop_nxt;
  out_item_t         out_r, out_nxt;
  logic              strobe_r, strobe_nxt;

  logic [2*GRID_W-1:0]      total;
  logic [GRID_W-1:0]        sh_s, sh_d;
  logic                     qb_s, qb_d;
  logic [NODE_W+GRID_W-1:0] prod;
  logic [NODE_W-1:0]        node_cur;
  logic                     at_dest;
  logic                     capped;

  assign total = (2*GRID_W)'(grid_rows) * (2*GRID_W)'(grid_cols);

  assign stat.bad = (grid_rows == '0) || (grid_cols == '0) ||
                    (total > (2*GRID_W)'(MAX_NODES)) ||
                    ((2*GRID_W)'(cr_r) >= total) || ((2*GRID_W)'(dr_r) >= total);

  assign sh_s = {cc_r[GRID_W-2:0], cr_r[NODE_W-1]};
  assign sh_d = {dc_r[GRID_W-2:0], dr_r[NODE_W-1]};
  assign qb_s = (sh_s >= grid_cols);
  assign qb_d = (sh_d >= grid_cols);

  assign prod     = (NODE_W+GRID_W)'(cr_r) * (NODE_W+GRID_W)'(grid_cols);
  assign node_cur = prod[NODE_W-1:0] + cc_r[NODE_W-1:0];
  assign at_dest  = (cr_r == dr_r) && (cc_r == dc_r);
  assign capped   = (hop_r == LAST_HOP);

  assign stat.route_done = at_dest || capped;

  always_comb begin
    cr_nxt     = cr_r;
    cc_nxt     = cc_r;
    dr_nxt     = dr_r;
    dc_nxt     = dc_r;
    hop_nxt    = hop_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    priority if (cmd.load) begin
      cr_nxt  = in_item.src_node;
      dr_nxt  = in_item.dst_node;
      cc_nxt  = '0;
      dc_nxt  = '0;
      hop_nxt = '0;
    end else if (cmd.emit_bad) begin
      out_nxt.node      = '0;
      out_nxt.hop_index = '0;
      out_nxt.last      = 1'b1;
      out_nxt.invalid   = 1'b1;
      strobe_nxt        = 1'b1;
    end else if (cmd.div_step) begin
      cr_nxt = {cr_r[NODE_W-2:0], qb_s};
      dr_nxt = {dr_r[NODE_W-2:0], qb_d};
      cc_nxt = qb_s ? (sh_s - grid_cols) : sh_s;
      dc_nxt = qb_d ? (sh_d - grid_cols) : sh_d;
    end else if (cmd.hop_step) begin
      out_nxt.node      = node_cur;
      out_nxt.hop_index = hop_r;
      out_nxt.last      = at_dest || capped;
      out_nxt.invalid   = 1'b0;
      strobe_nxt        = 1'b1;
      hop_nxt           = hop_r + NODE_W'(1);
      if (cc_r != dc_r) begin
        cc_nxt = ring_step(cc_r, dc_r, grid_cols);
      end else begin
        cr_nxt = NODE_W'(ring_step(GRID_W'(cr_r), GRID_W'(dr_r), grid_rows));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r  <= cr_nxt;
    cc_r  <= cc_nxt;
    dr_r  <= dr_nxt;
    dc_r  <= dc_nxt;
    hop_r <= hop_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && out_r.invalid |-> out_r.last && (out_r.node == '0) &&
                                  (out_r.hop_index == '0))
    else $error("rejected result malformed");

  a_hop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !out_r.last |=> strobe_r &&
      (out_r.hop_index == $past(out_r.hop_index) + NODE_W'(1)))
    else $error("route hops not contiguous");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && out_r.last |=> !strobe_r)
    else $error("result right after final result");

endmodule

`default_nettype wire

/* hdl/torus_route_path_generator.sv */
// A rejected request gives its single result from the result register after the check state,
// and busy is already low while that result is shown. A valid request passes the check state
// and the division states, which split the nodes into row and column, then gives one route
// node per cycle. A new request is taken only while busy is low, so not before the last route
// node of the current request is shown.
// Results cannot be stalled. Synchronous active-low reset sets both grid registers to 1.
// Top level: APB configuration registers plus trp_ctrl and trp_dpath; uses trp_pkg.
`default_nettype none

module torus_route_path_generator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [trp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [trp_pkg::DATA_W-1:0] pwdata,
  output logic      [trp_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  input  wire trp_pkg::in_item_t          in_payload,
  output logic                            out_strobe,
  output trp_pkg::out_item_t              out_payload
);
  import trp_pkg::*;

  logic [GRID_W-1:0] rows_r, rows_nxt;
  logic [GRID_W-1:0] cols_r, cols_nxt;
  logic              wr_en;
  logic              reg_sel;
  trp_cmd_t          cmd;
  trp_stat_t         stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_ROWS: rows_nxt = pwdata[GRID_W-1:0];
        REG_COLS: cols_nxt = pwdata[GRID_W-1:0];
        default:  rows_nxt = rows_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= GRID_W'(1);
      cols_r <= GRID_W'(1);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  assign prdata = (reg_sel == REG_COLS) ? DATA_W'(cols_r) : DATA_W'(rows_r);

  trp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  trp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_payload),
    .grid_rows  (rows_r),
    .grid_cols  (cols_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_payload)
  );

endmodule

`default_nettype wire

/* tb/tb_torus_route_path_generator.sv */
// Self-checking testbench for torus_route_path_generator: directed and random route
// requests over many grid settings, with every route node checked against a predictor.
// Depends on trp_pkg and the torus_route_path_generator RTL only.
`timescale 1ns / 1ps

module tb_torus_route_path_generator;
  import trp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int N_DIRECTED    = 24;
  localparam int N_PHASES      = 12;
  localparam int ITEMS_PER_PHS = 34;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [GRID_W-1:0] rows;
    logic [GRID_W-1:0] cols;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    bit                typed;
    out_item_t         result;
  } route_case_t;

  localparam out_item_t REJECTED = '{node: '0, hop_index: '0, last: 1'b1, invalid: 1'b1};
  localparam out_item_t UNTYPED  = '{node: '0, hop_index: '0, last: 1'b0, invalid: 1'b0};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start;
  logic              busy;
  in_item_t          in_payload;
  logic              out_strobe;
  out_item_t         out_payload;

  logic [GRID_W-1:0] grid_rows_m;
  logic [GRID_W-1:0] grid_cols_m;
  out_item_t         route_nodes_q[$];
  int                idle_pct;
  int                mismatch_count;
  int                cycle_count;
  int                routes_sent;
  int                nodes_checked;
  int                grid_settings;
  route_case_t       directed_cases[N_DIRECTED];

  torus_route_path_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  function automatic int ring_next(input int from, input int to, input int size);
    int fwd;
    int bwd;
    fwd = (to + size - from) % size;
    bwd = (from + size - to) % size;
    return (fwd <= bwd) ? (from + 1) % size : (from + size - 1) % size;
  endfunction

  function automatic void predict_route(input in_item_t req);
    int        rows;
    int        cols;
    int        total;
    int        cr;
    int        cc;
    int        dr;
    int        dc;
    int        hop;
    bit        done;
    bit        capped;
    out_item_t step;
    rows  = int'(grid_rows_m);
    cols  = int'(grid_cols_m);
    total = rows * cols;
    if (rows == 0 || cols == 0 || total > MAX_NODES ||
        int'(req.src_node) >= total || int'(req.dst_node) >= total) begin
      route_nodes_q = {route_nodes_q, REJECTED};
      return;
    end
    cr  = int'(req.src_node) / cols;
    cc  = int'(req.src_node) % cols;
    dr  = int'(req.dst_node) / cols;
    dc  = int'(req.dst_node) % cols;
    hop = 0;
    forever begin
      done           = (cr == dr) && (cc == dc);
      capped         = (hop == ROUTE_CAP - 1);
      step.node      = NODE_W'(cr * cols + cc);
      step.hop_index = NODE_W'(hop);
      step.last      = done || capped;
      step.invalid   = 1'b0;
      route_nodes_q  = {route_nodes_q, step};
      hop++;
      if (done || capped) break;
      if (cc != dc) cc = ring_next(cc, dc, cols);
      else cr = ring_next(cr, dr, rows);
    end
  endfunction

  // Write one grid register and read it back; psel stays high for a following access.
  task automatic write_grid_reg(input logic idx, input logic [GRID_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_ROWS) grid_rows_m = val;
    else grid_cols_m = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== DATA_W'(val)) begin
      note_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, prdata, val));
    end
  endtask

  task automatic program_grid(input logic [GRID_W-1:0] rows, input logic [GRID_W-1:0] cols);
    write_grid_reg(REG_ROWS, rows);
    write_grid_reg(REG_COLS, cols);
    psel    <= 1'b0;
    penable <= 1'b0;
    grid_settings++;
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (route_nodes_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Returns at the clock edge where the request transfer takes place.
  task automatic issue_request(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (busy !== 1'b0);
    routes_sent++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (route_nodes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result node %0d hop %0d last %0b invalid %0b",
                                out_payload.node, out_payload.hop_index,
                                out_payload.last, out_payload.invalid));
      end else begin
        want = route_nodes_q.pop_front();
        nodes_checked++;
        if (out_payload.node !== want.node || out_payload.hop_index !== want.hop_index ||
            out_payload.last !== want.last || out_payload.invalid !== want.invalid) begin
          note_mismatch($sformatf(
            "want node %0d hop %0d last %0b inv %0b, got node %0d hop %0d last %0b inv %0b",
            want.node, want.hop_index, want.last, want.invalid,
            out_payload.node, out_payload.hop_index, out_payload.last, out_payload.invalid));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t          req;
    route_case_t       rc;
    logic [GRID_W-1:0] rows;
    logic [GRID_W-1:0] cols;
    int                total;
    int                ph;
    int                n;
    logic [GRID_W-1:0] phase_rows[N_PHASES];
    logic [GRID_W-1:0] phase_cols[N_PHASES];
    bit                phase_rand[N_PHASES];

    rst_n      <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    start      <= 1'b0;
    in_payload <= '0;
    grid_rows_m    = 7'd1;
    grid_cols_m    = 7'd1;
    mismatch_count = 0;
    cycle_count    = 0;
    routes_sent    = 0;
    nodes_checked  = 0;
    grid_settings  = 0;
    idle_pct       = 28;

    directed_cases = '{
      '{7'd1,   7'd1,   6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b1, 1'b0}},
      '{7'd1,   7'd1,   6'd0,  6'd1,  1'b1, REJECTED},
      '{7'd1,   7'd1,   6'd63, 6'd63, 1'b1, REJECTED},
      '{7'd8,   7'd8,   6'd0,  6'd63, 1'b0, UNTYPED},
      '{7'd8,   7'd8,   6'd63, 6'd0,  1'b0, UNTYPED},
      '{7'd8,   7'd8,   6'd0,  6'd36, 1'b0, UNTYPED},
      '{7'd8,   7'd8,   6'd27, 6'd27, 1'b1, '{6'd27, 6'd0, 1'b1, 1'b0}},
      '{7'd8,   7'd8,   6'd10, 6'd53, 1'b0, UNTYPED},
      '{7'd8,   7'd8,   6'd42, 6'd21, 1'b0, UNTYPED},
      '{7'd1,   7'd64,  6'd0,  6'd32, 1'b0, UNTYPED},
      '{7'd1,   7'd64,  6'd63, 6'd31, 1'b0, UNTYPED},
      '{7'd64,  7'd1,   6'd0,  6'd32, 1'b0, UNTYPED},
      '{7'd64,  7'd1,   6'd63, 6'd0,  1'b0, UNTYPED},
      '{7'd0,   7'd5,   6'd1,  6'd2,  1'b1, REJECTED},
      '{7'd5,   7'd0,   6'd1,  6'd2,  1'b1, REJECTED},
      '{7'd127, 7'd127, 6'd0,  6'd1,  1'b1, REJECTED},
      '{7'd9,   7'd8,   6'd0,  6'd0,  1'b1, REJECTED},
      '{7'd64,  7'd64,  6'd0,  6'd0,  1'b1, REJECTED},
      '{7'd3,   7'd5,   6'd14, 6'd0,  1'b0, UNTYPED},
      '{7'd3,   7'd5,   6'd15, 6'd0,  1'b1, REJECTED},
      '{7'd3,   7'd5,   6'd0,  6'd15, 1'b1, REJECTED},
      '{7'd7,   7'd9,   6'd62, 6'd0,  1'b0, UNTYPED},
      '{7'd7,   7'd9,   6'd0,  6'd63, 1'b1, REJECTED},
      '{7'd2,   7'd32,  6'd5,  6'd48, 1'b0, UNTYPED}
    };
    phase_rows = '{7'd8, 7'd1,  7'd64, 7'd4,  7'd3,  7'd9, 7'd2,  7'd16, 7'd7, 7'd5,  7'd6,  7'd64};
    phase_cols = '{7'd8, 7'd64, 7'd1,  7'd16, 7'd21, 7'd8, 7'd32, 7'd4,  7'd9, 7'd12, 7'd10, 7'd2};
    phase_rand = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cases[i]) begin
      rc = directed_cases[i];
      if (rc.rows != grid_rows_m || rc.cols != grid_cols_m) begin
        wait_until_drained();
        program_grid(rc.rows, rc.cols);
      end
      req.src_node = rc.src;
      req.dst_node = rc.dst;
      issue_request(req);
      if (rc.typed) route_nodes_q = {route_nodes_q, rc.result};
      else predict_route(req);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = (ph < 4) ? 28 : (ph < 8) ? 78 : 0;
      if (phase_rand[ph]) begin
        rows = GRID_W'($urandom_range(64, 1));
        cols = GRID_W'($urandom_range(64 / int'(rows), 1));
      end else begin
        rows = phase_rows[ph];
        cols = phase_cols[ph];
      end
      wait_until_drained();
      program_grid(rows, cols);
      total = int'(rows) * int'(cols);
      for (n = 0; n < ITEMS_PER_PHS; n++) begin
        if (total <= MAX_NODES && $urandom_range(99) < 85) begin
          req.src_node = NODE_W'($urandom_range(total - 1));
          req.dst_node = ($urandom_range(9) == 0) ? req.src_node
                                                  : NODE_W'($urandom_range(total - 1));
        end else begin
          req.src_node = NODE_W'($urandom_range(63));
          req.dst_node = NODE_W'($urandom_range(63));
        end
        issue_request(req);
        predict_route(req);
      end
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d route requests over %0d grid settings; %0d route nodes checked.",
             routes_sent, grid_settings, nodes_checked);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0 && route_nodes_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/trp_pkg.sv
hdl/trp_ctrl.sv
hdl/trp_dpath.sv
hdl/torus_route_path_generator.sv
tb/tb_torus_route_path_generator.sv
